>>> sv/drrc_pkg.sv
// package for the dark region ring classifier
// types, register indexes, reset constants and the ring test; no dependencies
package drrc_pkg;

    // channel and register widths
    localparam int CH_W     = 8;
    localparam int PIX_W    = 3 * CH_W;
    localparam int CFG_DW   = 11;
    localparam int CFG_AW   = 2;

    // defaults and reset values
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int FRAME_RESET    = 1024;
    localparam logic [CH_W-1:0] THRESH_RESET = 8'd16;
    localparam logic [CH_W-1:0] FULL_CHANNEL = 8'hFF;

    // register indexes on the configuration port
    typedef enum logic [CFG_AW-1:0] {
        REG_THRESHOLD = 2'd0,
        REG_WIDTH     = 2'd1,
        REG_HEIGHT    = 2'd2
    } t_reg_idx;

    // item commands
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // one result word
    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
        logic            recolored;
        logic            frame_end;
    } t_result;

    // three consecutive dark members in the circular 8-neighbour ring
    // window: bits 6..8 oldest column, 0..2 newest; bit 0 top, 1 centre row, 2 bottom
    function automatic logic ring_has_run(input logic [8:0] win);
        logic [7:0] ring;
        logic [7:0] run;
        ring = {win[7], win[8], win[5], win[2], win[1], win[0], win[3], win[6]};
        for (int k = 0; k < 8; k++) begin
            run[k] = ring[k] & ring[(k + 1) % 8] & ring[(k + 2) % 8];
        end
        return |run;
    endfunction

endpackage

>>> sv/dark_region_ring_classifier.sv
// dark region ring classifier, top level
// line memory, 3x3 dark window, output register with skid; uses drrc_pkg
//
//  channel | direction | handshake                  | word
//  --------+-----------+----------------------------+--------------------------------
//  in      | input     | i_in_valid / o_in_stall    | cmd, blue, green, red
//  out     | output    | o_out_valid / i_out_stall  | blue, green, red, recolored, end
//  cfg     | input     | i_cfg_we                   | i_cfg_addr, i_cfg_data
//
// one word per clock while o_in_stall is low; a result is registered as its word is
// taken, frame_width+1 words behind the pixel stream (flush words drain the rest).
// the line memory is read ahead at the column the next word needs. reset is
// synchronous and clears control only; the line memory holds no reset value and
// needs no clearing pass. o_in_stall rises only while the skid word is full.
module dark_region_ring_classifier #(
    parameter int MAX_WIDTH  = drrc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = drrc_pkg::DEF_MAX_HEIGHT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input word
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_cmd,
    input  logic [drrc_pkg::CH_W-1:0]   i_blue_in,
    input  logic [drrc_pkg::CH_W-1:0]   i_green_in,
    input  logic [drrc_pkg::CH_W-1:0]   i_red_in,
    // output word
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [drrc_pkg::CH_W-1:0]   o_blue_out,
    output logic [drrc_pkg::CH_W-1:0]   o_green_out,
    output logic [drrc_pkg::CH_W-1:0]   o_red_out,
    output logic                        o_recolored,
    output logic                        o_frame_end,
    // configuration writes
    input  logic                        i_cfg_we,
    input  logic [drrc_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [drrc_pkg::CFG_DW-1:0] i_cfg_data
);
    import drrc_pkg::*;

    localparam int AW   = $clog2(MAX_WIDTH);
    localparam int HAW  = $clog2(MAX_HEIGHT);
    localparam int HXW  = $clog2(MAX_HEIGHT + 1);
    localparam int EW   = PIX_W + 2;
    localparam int RST_W = (FRAME_RESET > MAX_WIDTH)  ? MAX_WIDTH  : FRAME_RESET;
    localparam int RST_H = (FRAME_RESET > MAX_HEIGHT) ? MAX_HEIGHT : FRAME_RESET;

    // line memory entry: {pixel, dark of this row, dark of row above}
    logic [EW-1:0]    r_mem [MAX_WIDTH];
    logic [EW-1:0]    r_rd_q;
    logic [EW-1:0]    r_byp_data;
    logic             r_byp_valid;

    logic [CH_W-1:0]  r_thresh,   n_thresh;
    logic [AW-1:0]    r_last_col, n_last_col;
    logic [HAW-1:0]   r_last_row, n_last_row;
    logic [8:0]       r_win,      n_win;
    logic [PIX_W-1:0] r_cpix,     n_cpix;
    logic             r_cdark,    n_cdark;
    logic [AW-1:0]    r_in_col,   n_in_col;
    logic [HXW-1:0]   r_in_row,   n_in_row;
    logic [AW-1:0]    r_out_col,  n_out_col;
    logic [HAW-1:0]   r_out_row,  n_out_row;

    t_result          r_out,  r_skid, res;
    logic             r_out_valid, r_skid_valid;

    logic             acc, complete, n_complete, new_dark, border, last_px;
    logic             res_v, src_dark, ring_hit, hit, wr_en;
    logic [PIX_W-1:0] src_pix;
    logic [EW-1:0]    old_e, wr_data;
    logic [AW-1:0]    rd_addr;
    int unsigned      cfg_v, last_w, last_h;

    // clamp of the geometry registers to 1..max, held as last index
    always_comb begin
        cfg_v  = 32'(i_cfg_data);
        last_w = (cfg_v == 0) ? 0 : ((cfg_v > MAX_WIDTH)  ? MAX_WIDTH - 1  : cfg_v - 1);
        last_h = (cfg_v == 0) ? 0 : ((cfg_v > MAX_HEIGHT) ? MAX_HEIGHT - 1 : cfg_v - 1);
    end

    // classification and next state
    always_comb begin
        acc      = i_in_valid && !r_skid_valid;
        complete = r_in_row > HXW'(r_last_row);
        old_e    = r_byp_valid ? r_byp_data : r_rd_q;
        new_dark = i_blue_in < r_thresh;
        border   = (r_out_row == '0) || (r_out_row == r_last_row) ||
                   (r_out_col == '0) || (r_out_col == r_last_col);
        last_px  = (r_out_row == r_last_row) && (r_out_col == r_last_col);

        n_thresh   = r_thresh;
        n_last_col = r_last_col;
        n_last_row = r_last_row;
        n_win      = r_win;
        n_cpix     = r_cpix;
        n_cdark    = r_cdark;
        n_in_col   = r_in_col;
        n_in_row   = r_in_row;
        n_out_col  = r_out_col;
        n_out_row  = r_out_row;
        res_v      = 1'b0;
        src_pix    = r_cpix;
        src_dark   = r_cdark;
        ring_hit   = 1'b0;
        wr_en      = 1'b0;
        wr_data    = {i_red_in, i_green_in, i_blue_in, new_dark, old_e[1]};

        // pixel word: shift window, update line, advance input position
        if (acc && i_cmd == CMD_PIXEL && !complete) begin
            wr_en   = 1'b1;
            n_win   = {r_win[5:0], new_dark, old_e[1], old_e[0]};
            n_cpix  = old_e[EW-1:2];
            n_cdark = old_e[1];
            if (r_in_col == r_last_col) begin
                n_in_col = '0;
                n_in_row = r_in_row + 1'b1;
            end else begin
                n_in_col = r_in_col + 1'b1;
            end
            // output once the row below the centre has begun
            if (r_in_row >= HXW'(2) || (r_in_row == HXW'(1) && r_in_col != '0)) begin
                res_v    = 1'b1;
                ring_hit = ring_has_run(n_win);
            end
        end

        // flush word: drain one pending pixel
        if (acc && i_cmd == CMD_FLUSH && complete) begin
            res_v = 1'b1;
            if (r_out_row == r_last_row) begin
                src_pix  = old_e[EW-1:2];
                src_dark = old_e[1];
            end
        end

        hit           = res_v && src_dark && (border || ring_hit);
        res.blue      = hit ? FULL_CHANNEL : src_pix[CH_W-1:0];
        res.green     = hit ? '0 : src_pix[2*CH_W-1:CH_W];
        res.red       = hit ? '0 : src_pix[3*CH_W-1:2*CH_W];
        res.recolored = hit;
        res.frame_end = last_px;

        // output position
        if (res_v) begin
            if (r_out_col == r_last_col) begin
                n_out_col = '0;
                n_out_row = r_out_row + 1'b1;
            end else begin
                n_out_col = r_out_col + 1'b1;
            end
        end

        // end of frame restarts
        if (res_v && last_px) begin
            n_win     = '0;
            n_cpix    = '0;
            n_cdark   = 1'b0;
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
        end

        // register writes; geometry restarts the frame
        if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_THRESHOLD: n_thresh = i_cfg_data[CH_W-1:0];
                REG_WIDTH:     n_last_col = AW'(last_w);
                REG_HEIGHT:    n_last_row = HAW'(last_h);
                default:       ;
            endcase
            if (i_cfg_addr == REG_WIDTH || i_cfg_addr == REG_HEIGHT) begin
                n_win     = '0;
                n_cpix    = '0;
                n_cdark   = 1'b0;
                n_in_col  = '0;
                n_in_row  = '0;
                n_out_col = '0;
                n_out_row = '0;
            end
        end

        // read ahead at the column the next word needs
        n_complete = n_in_row > HXW'(n_last_row);
        rd_addr    = n_complete ? n_out_col : n_in_col;
    end

    // line memory, read before write
    always_ff @(posedge i_clk) begin
        r_rd_q <= r_mem[rd_addr];
        if (wr_en) begin
            r_mem[r_in_col] <= wr_data;
        end
    end

    // bypass for a write to the address being read ahead
    always_ff @(posedge i_clk) begin
        r_byp_data <= wr_data;
        if (!i_rst_n) begin
            r_byp_valid <= 1'b0;
        end else begin
            r_byp_valid <= wr_en && (r_in_col == rd_addr);
        end
    end

    // control and window state
    always_ff @(posedge i_clk) begin
        r_cpix <= n_cpix;
        if (!i_rst_n) begin
            r_thresh   <= THRESH_RESET;
            r_last_col <= AW'(RST_W - 1);
            r_last_row <= HAW'(RST_H - 1);
            r_win      <= '0;
            r_cdark    <= 1'b0;
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
        end else begin
            r_thresh   <= n_thresh;
            r_last_col <= n_last_col;
            r_last_row <= n_last_row;
            r_win      <= n_win;
            r_cdark    <= n_cdark;
            r_in_col   <= n_in_col;
            r_in_row   <= n_in_row;
            r_out_col  <= n_out_col;
            r_out_row  <= n_out_row;
        end
    end

    // output register with skid word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || !i_out_stall) begin
            if (r_skid_valid) begin
                r_out        <= r_skid;
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out        <= res;
                r_out_valid  <= res_v;
            end
        end else if (res_v) begin
            r_skid       <= res;
            r_skid_valid <= 1'b1;
        end
    end

    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_blue_out  = r_out.blue;
    assign o_green_out = r_out.green;
    assign o_red_out   = r_out.red;
    assign o_recolored = r_out.recolored;
    assign o_frame_end = r_out.frame_end;

endmodule

>>> tb/tb.sv
// testbench for dark_region_ring_classifier: directed and random pixel frames
// checked word by word against a behavioural predictor held in a small class
// depends on drrc_pkg and the classifier rtl only
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import drrc_pkg::*;

    localparam int unsigned LINE_DEPTH  = DEF_MAX_WIDTH;
    localparam int unsigned ROW_LIMIT   = DEF_MAX_HEIGHT;
    localparam int          CYCLE_LIMIT = 600000;
    localparam int          SETTLE      = 8;
    localparam int          NOISE_PCT   = 5;
    localparam int          HOLD_CYCLES = 300;
    localparam int          PHASE_WORDS = 40;
    // index with no register behind it
    localparam logic [CFG_AW-1:0] REG_NONE = 2'd3;

    // predictor of the classified pixel stream and store of pixels still owed
    class dark_ring_tracker;
        logic [CH_W-1:0]   thresh;
        logic [CFG_DW-1:0] width_reg;
        logic [CFG_DW-1:0] height_reg;
        bit [PIX_W-1:0]    line_pix [LINE_DEPTH];
        bit                line_dark_top [LINE_DEPTH];
        bit                line_dark_mid [LINE_DEPTH];
        bit [8:0]          win;
        bit [PIX_W-1:0]    delay_pix [2];
        bit                delay_dark [2];
        int unsigned       col;
        int unsigned       row;
        int unsigned       emitted;
        t_result           owed_q [$];
        int                errors;

        function new();
            thresh     = THRESH_RESET;
            width_reg  = CFG_DW'(FRAME_RESET);
            height_reg = CFG_DW'(FRAME_RESET);
            errors     = 0;
            restart();
        endfunction

        function void restart();
            win           = '0;
            delay_pix[0]  = '0;
            delay_pix[1]  = '0;
            delay_dark[0] = 1'b0;
            delay_dark[1] = 1'b0;
            col           = 0;
            row           = 0;
            emitted       = 0;
        endfunction

        function int unsigned frame_w();
            int unsigned v;
            v = width_reg;
            if (v < 1) v = 1;
            if (v > LINE_DEPTH) v = LINE_DEPTH;
            return v;
        endfunction

        function int unsigned frame_h();
            int unsigned v;
            v = height_reg;
            if (v < 1) v = 1;
            if (v > ROW_LIMIT) v = ROW_LIMIT;
            return v;
        endfunction

        function bit frame_complete();
            return row >= frame_h();
        endfunction

        function bit in_progress();
            return (row != 0) || (col != 0) || (emitted != 0);
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        // register write as the block sees it; geometry restarts the frame
        function void write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] data);
            case (idx)
                REG_THRESHOLD: begin
                    thresh = data[CH_W-1:0];
                end
                REG_WIDTH: begin
                    width_reg = data;
                    restart();
                end
                REG_HEIGHT: begin
                    height_reg = data;
                    restart();
                end
                default: begin
                end
            endcase
        endfunction

        // circular run of three dark neighbours, clockwise from top-left
        function bit ring_run(bit [8:0] wb);
            bit [7:0]  ring;
            bit [15:0] twice;
            bit [15:0] run;
            ring[0] = wb[6];
            ring[1] = wb[3];
            ring[2] = wb[0];
            ring[3] = wb[1];
            ring[4] = wb[2];
            ring[5] = wb[5];
            ring[6] = wb[8];
            ring[7] = wb[7];
            twice   = {ring, ring};
            run     = twice & (twice >> 1) & (twice >> 2);
            return run[7:0] != 8'd0;
        endfunction

        // classify output pixel number idx and queue the word it should give
        function void owe_pixel(bit [PIX_W-1:0] pix, bit dark, int unsigned idx, bit [8:0] wb);
            int unsigned w;
            int unsigned h;
            int unsigned r;
            int unsigned c;
            bit          border;
            bit          hit;
            t_result     px;
            w      = frame_w();
            h      = frame_h();
            r      = idx / w;
            c      = idx % w;
            border = (r == 0) || (r == h - 1) || (c == 0) || (c == w - 1);
            hit    = dark && (border || ring_run(wb));
            if (hit) begin
                px.blue  = FULL_CHANNEL;
                px.green = '0;
                px.red   = '0;
            end else begin
                px.blue  = pix[CH_W-1:0];
                px.green = pix[2*CH_W-1:CH_W];
                px.red   = pix[3*CH_W-1:2*CH_W];
            end
            px.recolored = hit;
            px.frame_end = (idx == w * h - 1);
            owed_q.push_back(px);
        endfunction

        // one accepted input word
        function void take_word(logic cmd, logic [CH_W-1:0] b, logic [CH_W-1:0] g,
                                logic [CH_W-1:0] r);
            int unsigned w;
            int unsigned h;
            int unsigned total;
            int unsigned arrived;
            int unsigned c;
            int unsigned idx;
            bit          fresh_dark;
            bit          old_mid;
            bit          old_top;
            bit [PIX_W-1:0] old_pix;
            w       = frame_w();
            h       = frame_h();
            total   = w * h;
            arrived = row * w + col;
            if (cmd == CMD_FLUSH) begin
                // drain: nothing before the frame is in, one pixel per word after
                if (!frame_complete() || emitted >= total) return;
                idx = emitted;
                if (idx < total - w) begin
                    owe_pixel(delay_pix[0], delay_dark[0], idx, 9'd0);
                end else begin
                    c = (idx - (total - w)) % LINE_DEPTH;
                    owe_pixel(line_pix[c], line_dark_mid[c], idx, 9'd0);
                end
                emitted = idx + 1;
                if (emitted >= total) restart();
                return;
            end
            if (frame_complete()) return;
            c          = col % LINE_DEPTH;
            fresh_dark = b < thresh;
            old_pix    = line_pix[c];
            old_mid    = line_dark_mid[c];
            old_top    = line_dark_top[c];
            // newest window column: top, centre, bottom
            win              = {win[5:0], fresh_dark, old_mid, old_top};
            line_dark_top[c] = old_mid;
            line_dark_mid[c] = fresh_dark;
            line_pix[c]      = {r, g, b};
            delay_pix[1]     = delay_pix[0];
            delay_dark[1]    = delay_dark[0];
            delay_pix[0]     = old_pix;
            delay_dark[0]    = old_mid;
            col++;
            if (col >= w) begin
                col = 0;
                row++;
            end
            if (arrived >= w + 1) begin
                idx = arrived - w - 1;
                owe_pixel(delay_pix[1], delay_dark[1], idx, win);
                emitted = idx + 1;
            end
        endfunction

        function void compare_field(string field, logic [CH_W-1:0] want, logic [CH_W-1:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
            end
        endfunction

        // one accepted output word against the oldest owed pixel
        function void match_word(t_result got);
            t_result want;
            if (owed_q.size() == 0) begin
                errors++;
                $display("%0t: output word with nothing owed, expected none, got %h",
                         $time, got);
                return;
            end
            want = owed_q.pop_front();
            compare_field("blue", want.blue, got.blue);
            compare_field("green", want.green, got.green);
            compare_field("red", want.red, got.red);
            compare_field("recolored", CH_W'(want.recolored), CH_W'(got.recolored));
            compare_field("frame_end", CH_W'(want.frame_end), CH_W'(got.frame_end));
        endfunction
    endclass

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_stall;
    logic                i_cmd       = CMD_PIXEL;
    logic [CH_W-1:0]     i_blue_in   = '0;
    logic [CH_W-1:0]     i_green_in  = '0;
    logic [CH_W-1:0]     i_red_in    = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    logic [CH_W-1:0]     o_blue_out;
    logic [CH_W-1:0]     o_green_out;
    logic [CH_W-1:0]     o_red_out;
    logic                o_recolored;
    logic                o_frame_end;
    logic                i_cfg_we    = 1'b0;
    logic [CFG_AW-1:0]   i_cfg_addr  = '0;
    logic [CFG_DW-1:0]   i_cfg_data  = '0;

    dark_ring_tracker tracker = new();

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_req      = 0;
    int hold_left     = 0;
    int words_counted = 0;
    int cycle_count   = 0;

    dark_region_ring_classifier dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_cmd       (i_cmd),
        .i_blue_in   (i_blue_in),
        .i_green_in  (i_green_in),
        .i_red_in    (i_red_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_blue_out  (o_blue_out),
        .o_green_out (o_green_out),
        .o_red_out   (o_red_out),
        .o_recolored (o_recolored),
        .o_frame_end (o_frame_end),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // receiver: random stall, or a long hold-off when one is requested
    always @(negedge i_clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // monitor: check the output word before noting the input word of the same edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall)
                tracker.match_word(t_result'({o_blue_out, o_green_out, o_red_out,
                                              o_recolored, o_frame_end}));
            if (i_in_valid && !o_in_stall)
                tracker.take_word(i_cmd, i_blue_in, i_green_in, i_red_in);
        end
    end

    // offer one word from a falling edge; returns on the falling edge after acceptance
    task automatic send_word(logic cmd, logic [CH_W-1:0] b, logic [CH_W-1:0] g,
                             logic [CH_W-1:0] r);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_blue_in  <= b;
        i_green_in <= g;
        i_red_in   <= r;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic stop_sending();
        i_in_valid <= 1'b0;
    endtask

    // hold the sender until every owed pixel has come out, then let the block settle
    task automatic wait_drained();
        while (tracker.pending() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        tracker.write_reg(idx, data);
        @(negedge i_clk);
    endtask

    task automatic cfg_release();
        i_cfg_we <= 1'b0;
    endtask

    // blue value biased around the threshold so dark runs are common
    function automatic logic [CH_W-1:0] pick_blue();
        int thr;
        thr = tracker.thresh;
        if ($urandom_range(0, 99) < 20) return CH_W'($urandom);
        if (thr != 0 && $urandom_range(0, 99) < 55) return CH_W'($urandom_range(0, thr - 1));
        return CH_W'($urandom_range(thr, 255));
    endfunction

    // pixels until the frame is in (or stop_at pixels), then flush words to its end
    task automatic run_frame(int stop_at);
        int sent;
        sent = 0;
        while (!tracker.frame_complete()) begin
            if (stop_at >= 0 && sent >= stop_at) return;
            // early flush, no result
            if ($urandom_range(0, 99) < NOISE_PCT)
                send_word(CMD_FLUSH, CH_W'($urandom), CH_W'($urandom), CH_W'($urandom));
            send_word(CMD_PIXEL, pick_blue(), CH_W'($urandom), CH_W'($urandom));
            sent++;
            words_counted++;
        end
        while (tracker.frame_complete()) begin
            // pixel while draining, ignored
            if ($urandom_range(0, 99) < NOISE_PCT)
                send_word(CMD_PIXEL, CH_W'($urandom), CH_W'($urandom), CH_W'($urandom));
            send_word(CMD_FLUSH, CH_W'($urandom), CH_W'($urandom), CH_W'($urandom));
            words_counted++;
        end
    endtask

    // hand-built 4x3 frame: border darks, a wrapping ring run, a dark pixel without a run
    task automatic run_directed();
        logic [CH_W-1:0] blues [12] = '{8'd0, 8'd15, 8'd16, 8'd255,
                                        8'd3, 8'd15, 8'd8, 8'd200,
                                        8'd255, 8'd20, 8'd128, 8'd0};
        write_reg(REG_WIDTH, 11'd4);
        write_reg(REG_HEIGHT, 11'd3);
        write_reg(REG_NONE, 11'h7FF);
        cfg_release();
        for (int i = 0; i < 12; i++) begin
            send_word(CMD_PIXEL, blues[i], i[0] ? 8'hAA : 8'h55, i[0] ? 8'h00 : 8'hFF);
            if (i == 0) send_word(CMD_FLUSH, 8'hFF, 8'hFF, 8'hFF);
        end
        send_word(CMD_PIXEL, 8'd0, 8'd0, 8'd0);
        while (tracker.frame_complete()) send_word(CMD_FLUSH, 8'd0, 8'd0, 8'd0);
        send_word(CMD_FLUSH, 8'd0, 8'd0, 8'd0);
        stop_sending();
        wait_drained();
    endtask

    // one phase: idling mode from p/2, geometry extremes on even phases
    task automatic run_phase(int p);
        int          start;
        int unsigned w;
        int unsigned h;
        logic [CH_W-1:0] thr;
        start = words_counted;
        case (p / 2)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 76; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 76; end
            default: begin send_idle_pct = 30; stall_pct = 30; end
        endcase
        thr = CH_W'($urandom_range(8, 200));
        if (p == 2 || p == 7) thr = 8'd255;
        if (p == 4) thr = 8'd0;
        case (p)
            0: begin w = 8;    h = 1;    end
            1: begin w = 6;    h = 5;    end
            2: begin w = 0;    h = 0;    end
            4: begin w = 1;    h = 8;    end
            6: begin w = 9;    h = 7;    end
            default: begin
                w = $urandom_range(1, 9);
                h = $urandom_range(1, 7);
            end
        endcase
        if (p % 2 == 0 && tracker.in_progress() && $urandom_range(0, 1) == 1) begin
            // threshold only: the half-done frame carries on
            write_reg(REG_THRESHOLD, {3'($urandom), thr});
        end else begin
            write_reg(REG_WIDTH, CFG_DW'(w));
            write_reg(REG_HEIGHT, CFG_DW'(h));
            write_reg(REG_THRESHOLD, {3'($urandom), thr});
        end
        if ($urandom_range(0, 2) == 0) write_reg(REG_NONE, CFG_DW'($urandom));
        cfg_release();
        if (p == 1) begin
            // long receiver hold-off while words keep coming, then a pause mid-frame
            hold_req = HOLD_CYCLES;
            run_frame(tracker.frame_w() * tracker.frame_h() / 2);
            stop_sending();
            wait_drained();
        end
        while (words_counted - start < PHASE_WORDS) run_frame(-1);
        w = tracker.frame_w() * tracker.frame_h();
        if (p % 2 == 1 && w > 1 && $urandom_range(0, 99) < 40)
            run_frame($urandom_range(1, w - 1));
        stop_sending();
        wait_drained();
    endtask

    // main sequence
    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        run_directed();
        for (int p = 0; p < 8; p++) run_phase(p);
        if (tracker.errors == 0 && tracker.pending() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
